@@ hw/rtl/cms_pkg.sv @@
// Shared constants and types of the cube-map bilinear sampler.
`default_nettype none

package cms_pkg;

   localparam int MAX_FACE_EDGE_DEF    = 32;
   localparam int WEIGHT_FRAC_BITS_DEF = 12;

   localparam int FACE_COUNT = 6;
   localparam int CH_W       = 16;
   localparam int DIR_W      = 16;
   localparam int FACE_W     = 3;
   localparam int COORD_W    = 5;
   localparam int EDGE_W     = 6;
   localparam int TEXEL_W    = 4 * CH_W;
   localparam int AXIS_W     = DIR_W + 1;
   localparam int DEN_W      = DIR_W + 1;
   localparam int Q_DEPTH    = 4;
   localparam int OUT_DEPTH  = 2;

   localparam logic [EDGE_W-1:0] EDGE_RESET = 6'd32;

   localparam logic ACTION_WRITE  = 1'b0;
   localparam logic ACTION_SAMPLE = 1'b1;

   localparam logic [FACE_W-1:0] FACE_POS_X = 3'd0;
   localparam logic [FACE_W-1:0] FACE_NEG_X = 3'd1;
   localparam logic [FACE_W-1:0] FACE_POS_Y = 3'd2;
   localparam logic [FACE_W-1:0] FACE_NEG_Y = 3'd3;
   localparam logic [FACE_W-1:0] FACE_POS_Z = 3'd4;
   localparam logic [FACE_W-1:0] FACE_NEG_Z = 3'd5;

   typedef struct packed {
      logic               sample;
      logic [FACE_W-1:0]  face;
      logic               zero;
      logic [COORD_W-1:0] col;
      logic [COORD_W-1:0] row;
      logic [TEXEL_W-1:0] texel;
   } item_type;

   typedef struct packed {
      logic [CH_W-1:0]   red;
      logic [CH_W-1:0]   green;
      logic [CH_W-1:0]   blue;
      logic [CH_W-1:0]   alpha;
      logic [FACE_W-1:0] face;
      logic              zero;
   } result_type;

endpackage

`default_nettype wire

@@ hw/rtl/cms_fifo.sv @@
// Small register queue with push/pop handshake.
`default_nettype none

module cms_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic             pop,
   input  wire logic [WIDTH-1:0] wdata,
   output logic      [WIDTH-1:0] rdata,
   output logic                  full,
   output logic                  empty
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/cms_front.sv @@
// Front end: accepts items, picks the cube face and forms the division operands.
`default_nettype none

module cms_front #(
   parameter int MAX_FACE_EDGE    = 32,
   parameter int WEIGHT_FRAC_BITS = 12,
   localparam int EW = $clog2(MAX_FACE_EDGE + 1),
   localparam int QW = $clog2(MAX_FACE_EDGE) + WEIGHT_FRAC_BITS,
   localparam int RW = QW + cms_pkg::DEN_W
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                push,
   output logic                                     full,
   input  wire logic                                req_action,
   input  wire logic        [cms_pkg::FACE_W-1:0]   req_write_face,
   input  wire logic        [cms_pkg::COORD_W-1:0]  req_write_col,
   input  wire logic        [cms_pkg::COORD_W-1:0]  req_write_row,
   input  wire logic        [cms_pkg::CH_W-1:0]     req_red_in,
   input  wire logic        [cms_pkg::CH_W-1:0]     req_green_in,
   input  wire logic        [cms_pkg::CH_W-1:0]     req_blue_in,
   input  wire logic        [cms_pkg::CH_W-1:0]     req_alpha_in,
   input  wire logic signed [cms_pkg::DIR_W-1:0]    req_dir_x,
   input  wire logic signed [cms_pkg::DIR_W-1:0]    req_dir_y,
   input  wire logic signed [cms_pkg::DIR_W-1:0]    req_dir_z,
   input  wire logic        [EW-1:0]                edge_use,
   input  wire logic                                q_full,
   output logic                                     q_push,
   output cms_pkg::item_type                        q_item,
   output logic             [RW-1:0]                q_num_u,
   output logic             [RW-1:0]                q_num_v,
   output logic             [cms_pkg::DEN_W-1:0]    q_den
);
   import cms_pkg::*;

   localparam int PW = AXIS_W + EW + 2;

   logic signed [AXIS_W-1:0] dx, dy, dz, sc_c, tc_c;
   logic        [AXIS_W-1:0] ax, ay, az, ma_c;
   logic        [FACE_W-1:0] face_c;
   logic                     zero_c, good_write, keep, load;

   logic                     f_valid_ff, f_valid_in;
   item_type                 f_item_ff;
   logic signed [AXIS_W-1:0] f_sc_ff, f_tc_ff;
   logic        [AXIS_W-1:0] f_ma_ff;

   logic signed [PW-1:0]     eu_s, eum1_s, ma_s, num_u, num_v;

   always_comb begin
      dx = AXIS_W'(req_dir_x);
      dy = AXIS_W'(req_dir_y);
      dz = AXIS_W'(req_dir_z);
      ax = (dx < 0) ? AXIS_W'(-dx) : AXIS_W'(dx);
      ay = (dy < 0) ? AXIS_W'(-dy) : AXIS_W'(dy);
      az = (dz < 0) ? AXIS_W'(-dz) : AXIS_W'(dz);
      zero_c = (ax == '0) && (ay == '0) && (az == '0);
      if (zero_c) begin
         face_c = FACE_POS_X;
         sc_c   = '0;
         tc_c   = '0;
         ma_c   = AXIS_W'(1);
      end else if (ax >= ay && ax >= az) begin
         face_c = (dx >= 0) ? FACE_POS_X : FACE_NEG_X;
         sc_c   = (dx >= 0) ? -dz : dz;
         tc_c   = -dy;
         ma_c   = ax;
      end else if (ay >= az) begin
         face_c = (dy >= 0) ? FACE_POS_Y : FACE_NEG_Y;
         sc_c   = dx;
         tc_c   = (dy >= 0) ? dz : -dz;
         ma_c   = ay;
      end else begin
         face_c = (dz >= 0) ? FACE_POS_Z : FACE_NEG_Z;
         sc_c   = (dz >= 0) ? dx : -dx;
         tc_c   = -dy;
         ma_c   = az;
      end
      good_write = (int'(req_write_face) < FACE_COUNT)
                   && (int'(req_write_col) < MAX_FACE_EDGE)
                   && (int'(req_write_row) < MAX_FACE_EDGE);
      keep = (req_action == ACTION_SAMPLE) || good_write;
   end

   // drop bad writes here: they never leave a trace
   assign full   = f_valid_ff && q_full;
   assign load   = push && !full;
   assign q_push = f_valid_ff && !q_full;

   always_comb begin
      f_valid_in = f_valid_ff;
      if (load) begin
         f_valid_in = keep;
      end else if (q_push) begin
         f_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
      end else begin
         f_valid_ff <= f_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         f_item_ff.sample <= (req_action == ACTION_SAMPLE);
         f_item_ff.face   <= (req_action == ACTION_SAMPLE) ? face_c : req_write_face;
         f_item_ff.zero   <= zero_c;
         f_item_ff.col    <= req_write_col;
         f_item_ff.row    <= req_write_row;
         f_item_ff.texel  <= {req_alpha_in, req_blue_in, req_green_in, req_red_in};
         f_sc_ff          <= sc_c;
         f_tc_ff          <= tc_c;
         f_ma_ff          <= ma_c;
      end
   end

   // numerator 2^W*(sc*edge + (edge-1)*ma) + ma; negative positions become zero
   always_comb begin
      eu_s   = PW'($signed({1'b0, edge_use}));
      eum1_s = eu_s - PW'(1);
      ma_s   = PW'($signed({1'b0, f_ma_ff}));
      num_u  = PW'(f_sc_ff) * eu_s + eum1_s * ma_s;
      num_v  = PW'(f_tc_ff) * eu_s + eum1_s * ma_s;
      q_num_u = (num_u < 0) ? '0
                : (RW'($unsigned(num_u)) << WEIGHT_FRAC_BITS) + RW'(f_ma_ff);
      q_num_v = (num_v < 0) ? '0
                : (RW'($unsigned(num_v)) << WEIGHT_FRAC_BITS) + RW'(f_ma_ff);
      q_den   = DEN_W'({f_ma_ff, 1'b0});
   end

   assign q_item = f_item_ff;

endmodule

`default_nettype wire

@@ hw/rtl/cms_div.sv @@
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none

module cms_div #(
   parameter int QW = 17,
   parameter int RW = 34
) (
   input  wire logic                          clock,
   input  wire logic                          en,
   input  wire logic [RW-1:0]                 num,
   input  wire logic [cms_pkg::DEN_W-1:0]     den,
   output logic      [QW-1:0]                 quo
);
   import cms_pkg::*;

   logic [RW-1:0]    rem_ff  [QW-1];
   logic [DEN_W-1:0] den_ff  [QW-1];
   logic [QW-1:0]    quo_ff  [QW];
   logic [RW-1:0]    rem_prev [QW];
   logic [DEN_W-1:0] den_prev [QW];
   logic [QW-1:0]    quo_prev [QW];

   assign rem_prev[0] = num;
   assign den_prev[0] = den;
   assign quo_prev[0] = '0;

   for (genvar k = 0; k < QW; k++) begin : g_stage
      logic [RW-1:0] shifted, rem_in;
      logic [QW-1:0] quo_in;
      logic          ge;

      always_comb begin
         shifted = RW'(den_prev[k]) << (QW - 1 - k);
         ge      = (rem_prev[k] >= shifted);
         rem_in  = ge ? rem_prev[k] - shifted : rem_prev[k];
         quo_in  = quo_prev[k] | (QW'(ge) << (QW - 1 - k));
      end

      always_ff @(posedge clock) begin
         if (en) begin
            quo_ff[k] <= quo_in;
         end
      end

      if (k < QW - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[k] <= rem_in;
               den_ff[k] <= den_prev[k];
            end
         end
         assign rem_prev[k+1] = rem_ff[k];
         assign den_prev[k+1] = den_ff[k];
         assign quo_prev[k+1] = quo_ff[k];
      end
   end

   assign quo = quo_ff[QW-1];

endmodule

`default_nettype wire

@@ hw/rtl/cms_back.sv @@
// Back end: divides, writes and reads the four texel banks and blends the sample.
`default_nettype none

module cms_back #(
   parameter int MAX_FACE_EDGE    = 32,
   parameter int WEIGHT_FRAC_BITS = 12,
   localparam int EW = $clog2(MAX_FACE_EDGE + 1),
   localparam int QW = $clog2(MAX_FACE_EDGE) + WEIGHT_FRAC_BITS,
   localparam int RW = QW + cms_pkg::DEN_W
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [EW-1:0]                 edge_use,
   input  wire logic                          q_empty,
   output logic                               q_pop,
   input  wire cms_pkg::item_type             q_item,
   input  wire logic [RW-1:0]                 q_num_u,
   input  wire logic [RW-1:0]                 q_num_v,
   input  wire logic [cms_pkg::DEN_W-1:0]     q_den,
   input  wire logic                          out_full,
   output logic                               out_push,
   output cms_pkg::result_type                out_data
);
   import cms_pkg::*;

   localparam int W      = WEIGHT_FRAC_BITS;
   localparam int CW     = (MAX_FACE_EDGE > 1) ? $clog2(MAX_FACE_EDGE) : 1;
   localparam int HALF   = (MAX_FACE_EDGE + 1) / 2;
   localparam int FPB    = HALF * HALF;
   localparam int BDEPTH = FACE_COUNT * FPB;
   localparam int BAW    = $clog2(BDEPTH);
   localparam int PRW    = CH_W + W + 1;
   localparam int SRW    = PRW + W + 1;

   logic              en;
   logic              d_valid_ff [QW];
   item_type          d_item_ff  [QW];
   logic [QW-1:0]     quo_u, quo_v;
   item_type          t;
   logic              tv;

   int                last_i, whole_u, whole_v, x1_i, y1_i;
   logic [CW-1:0]     x0, x1, y0, y1;
   logic              wr_en;
   logic [1:0]        wr_bank;
   logic [BAW-1:0]    wr_addr;
   logic [BAW-1:0]    rd_addr [4];
   logic [TEXEL_W-1:0] rd_data [4];

   logic              m_valid_ff;
   logic [W-1:0]      m_fx_ff, m_fy_ff;
   logic              m_x0p_ff, m_x1p_ff, m_y0p_ff, m_y1p_ff;
   logic [FACE_W-1:0] m_face_ff;
   logic              m_zero_ff;

   logic              p_valid_ff;
   logic [PRW-1:0]    p_ff [4][4];
   logic [W-1:0]      p_fy_ff;
   logic [FACE_W-1:0] p_face_ff;
   logic              p_zero_ff;

   logic              s_valid_ff;
   logic [SRW-1:0]    s_ff [4][2];
   logic [FACE_W-1:0] s_face_ff;
   logic              s_zero_ff;

   logic [W:0]        wx0, wy0;
   logic [CH_W-1:0]   ch_out [4];

   // freeze the whole back end while the finished sample cannot be queued
   assign en    = !(s_valid_ff && out_full);
   assign q_pop = en && !q_empty;

   cms_div #(.QW(QW), .RW(RW)) u_div_u (
      .clock (clock), .en (en), .num (q_num_u), .den (q_den), .quo (quo_u)
   );
   cms_div #(.QW(QW), .RW(RW)) u_div_v (
      .clock (clock), .en (en), .num (q_num_v), .den (q_den), .quo (quo_v)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < QW; k++) begin
            d_valid_ff[k] <= 1'b0;
         end
      end else if (en) begin
         d_valid_ff[0] <= !q_empty;
         for (int k = 1; k < QW; k++) begin
            d_valid_ff[k] <= d_valid_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d_item_ff[0] <= q_item;
         for (int k = 1; k < QW; k++) begin
            d_item_ff[k] <= d_item_ff[k-1];
         end
      end
   end

   assign t  = d_item_ff[QW-1];
   assign tv = d_valid_ff[QW-1];

   // split positions into texel index pair and weight, clamp at the upper border
   always_comb begin
      last_i  = int'(edge_use) - 1;
      whole_u = int'(quo_u >> W);
      whole_v = int'(quo_v >> W);
      x0      = CW'((whole_u > last_i) ? last_i : whole_u);
      y0      = CW'((whole_v > last_i) ? last_i : whole_v);
      x1_i    = int'(x0) + 1;
      y1_i    = int'(y0) + 1;
      x1      = CW'((x1_i > last_i) ? last_i : x1_i);
      y1      = CW'((y1_i > last_i) ? last_i : y1_i);
      wr_en   = en && tv && !t.sample;
      wr_bank = {t.row[0], t.col[0]};
      wr_addr = BAW'(int'(t.face) * FPB + int'(t.row >> 1) * HALF + int'(t.col >> 1));
      for (int b = 0; b < 4; b++) begin
         rd_addr[b] = BAW'(int'(t.face) * FPB
                      + int'(((y0[0] == b[1]) ? y0 : y1) >> 1) * HALF
                      + int'(((x0[0] == b[0]) ? x0 : x1) >> 1));
      end
   end

   // banks split by column and row parity: the four texels never collide
   for (genvar b = 0; b < 4; b++) begin : g_bank
      logic [TEXEL_W-1:0] mem [BDEPTH];
      logic [TEXEL_W-1:0] bank_rd_ff;

      always_ff @(posedge clock) begin
         if (wr_en && wr_bank == 2'(b)) begin
            mem[wr_addr] <= t.texel;
         end
         if (en) begin
            bank_rd_ff <= mem[rd_addr[b]];
         end
      end

      assign rd_data[b] = bank_rd_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
         p_valid_ff <= 1'b0;
         s_valid_ff <= 1'b0;
      end else if (en) begin
         m_valid_ff <= tv && t.sample;
         p_valid_ff <= m_valid_ff;
         s_valid_ff <= p_valid_ff;
      end
   end

   assign wx0 = ((W+1)'(1) << W) - (W+1)'(m_fx_ff);
   assign wy0 = ((W+1)'(1) << W) - (W+1)'(p_fy_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         m_fx_ff   <= quo_u[W-1:0];
         m_fy_ff   <= quo_v[W-1:0];
         m_x0p_ff  <= x0[0];
         m_x1p_ff  <= x1[0];
         m_y0p_ff  <= y0[0];
         m_y1p_ff  <= y1[0];
         m_face_ff <= t.face;
         m_zero_ff <= t.zero;

         for (int c = 0; c < 4; c++) begin
            p_ff[c][0] <= PRW'(rd_data[{m_y0p_ff, m_x0p_ff}][CH_W*c +: CH_W]) * PRW'(wx0);
            p_ff[c][1] <= PRW'(rd_data[{m_y0p_ff, m_x1p_ff}][CH_W*c +: CH_W]) * PRW'(m_fx_ff);
            p_ff[c][2] <= PRW'(rd_data[{m_y1p_ff, m_x0p_ff}][CH_W*c +: CH_W]) * PRW'(wx0);
            p_ff[c][3] <= PRW'(rd_data[{m_y1p_ff, m_x1p_ff}][CH_W*c +: CH_W]) * PRW'(m_fx_ff);
         end
         p_fy_ff   <= m_fy_ff;
         p_face_ff <= m_face_ff;
         p_zero_ff <= m_zero_ff;

         for (int c = 0; c < 4; c++) begin
            s_ff[c][0] <= SRW'(p_ff[c][0] + p_ff[c][1]) * SRW'(wy0);
            s_ff[c][1] <= SRW'(p_ff[c][2] + p_ff[c][3]) * SRW'(p_fy_ff);
         end
         s_face_ff <= p_face_ff;
         s_zero_ff <= p_zero_ff;
      end
   end

   // round the column blend to nearest, halves upward
   always_comb begin
      for (int c = 0; c < 4; c++) begin
         logic [SRW:0] sum;
         sum = (SRW+1)'(s_ff[c][0]) + (SRW+1)'(s_ff[c][1])
               + ((SRW+1)'(1) << (2 * W - 1));
         ch_out[c] = sum[2*W +: CH_W];
      end
   end

   assign out_push       = en && s_valid_ff;
   assign out_data.red   = ch_out[0];
   assign out_data.green = ch_out[1];
   assign out_data.blue  = ch_out[2];
   assign out_data.alpha = ch_out[3];
   assign out_data.face  = s_face_ff;
   assign out_data.zero  = s_zero_ff;

   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      out_push |-> !out_full)
      else $error("result pushed into a full queue");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (s_valid_ff && out_full) |=> s_valid_ff)
      else $error("finished sample lost during stall");

   a_pop_enters: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> d_valid_ff[0])
      else $error("popped item did not enter the divider");

endmodule

`default_nettype wire

@@ hw/rtl/cubemap_bilinear_sampler.sv @@
// Path: an accepted beat passes the front register, the mid queue, the divider pipeline, the bank
// read and the m, p and s blend registers, then the response queue feeds the rsp_ ports.
// Throughput: one beat per cycle while full is low, writes and samples alike; writes give no result.
// Reset: clears all control state and sets face_edge to 32; texel banks are not cleared.
// Face edge is taken from the register and clamped to 1..MAX_FACE_EDGE.
`default_nettype none

module cubemap_bilinear_sampler #(
   parameter int MAX_FACE_EDGE    = cms_pkg::MAX_FACE_EDGE_DEF,
   parameter int WEIGHT_FRAC_BITS = cms_pkg::WEIGHT_FRAC_BITS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              push,
   output logic                                   full,
   input  wire logic                              req_action,
   input  wire logic        [cms_pkg::FACE_W-1:0] req_write_face,
   input  wire logic        [cms_pkg::COORD_W-1:0] req_write_col,
   input  wire logic        [cms_pkg::COORD_W-1:0] req_write_row,
   input  wire logic        [cms_pkg::CH_W-1:0]   req_red_in,
   input  wire logic        [cms_pkg::CH_W-1:0]   req_green_in,
   input  wire logic        [cms_pkg::CH_W-1:0]   req_blue_in,
   input  wire logic        [cms_pkg::CH_W-1:0]   req_alpha_in,
   input  wire logic signed [cms_pkg::DIR_W-1:0]  req_dir_x,
   input  wire logic signed [cms_pkg::DIR_W-1:0]  req_dir_y,
   input  wire logic signed [cms_pkg::DIR_W-1:0]  req_dir_z,
   output logic                                   empty,
   input  wire logic                              pop,
   output logic             [cms_pkg::CH_W-1:0]   rsp_red_out,
   output logic             [cms_pkg::CH_W-1:0]   rsp_green_out,
   output logic             [cms_pkg::CH_W-1:0]   rsp_blue_out,
   output logic             [cms_pkg::CH_W-1:0]   rsp_alpha_out,
   output logic             [cms_pkg::FACE_W-1:0] rsp_hit_face,
   output logic                                   rsp_zero_direction,
   input  wire logic                              csr_we,
   input  wire logic        [cms_pkg::EDGE_W-1:0] csr_wdata
);
   import cms_pkg::*;

   localparam int EW = $clog2(MAX_FACE_EDGE + 1);
   localparam int QW = $clog2(MAX_FACE_EDGE) + WEIGHT_FRAC_BITS;
   localparam int RW = QW + DEN_W;
   localparam int QD = $bits(item_type) + 2 * RW + DEN_W;
   localparam int OD = $bits(result_type);

   logic [EDGE_W-1:0] face_edge_ff;
   logic [EW-1:0]     edge_use;

   logic              f_push, q_full, q_empty, q_pop;
   item_type          f_item, b_item;
   logic [RW-1:0]     f_num_u, f_num_v, b_num_u, b_num_v;
   logic [DEN_W-1:0]  f_den, b_den;
   logic [QD-1:0]     q_rdata;

   logic              out_push, out_full;
   result_type        out_data, rsp_data;
   logic [OD-1:0]     rsp_rdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         face_edge_ff <= EDGE_RESET;
      end else if (csr_we) begin
         face_edge_ff <= csr_wdata;
      end
   end

   always_comb begin
      if (face_edge_ff == '0) begin
         edge_use = EW'(1);
      end else if (int'(face_edge_ff) > MAX_FACE_EDGE) begin
         edge_use = EW'(MAX_FACE_EDGE);
      end else begin
         edge_use = EW'(face_edge_ff);
      end
   end

   cms_front #(
      .MAX_FACE_EDGE    (MAX_FACE_EDGE),
      .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .full           (full),
      .req_action     (req_action),
      .req_write_face (req_write_face),
      .req_write_col  (req_write_col),
      .req_write_row  (req_write_row),
      .req_red_in     (req_red_in),
      .req_green_in   (req_green_in),
      .req_blue_in    (req_blue_in),
      .req_alpha_in   (req_alpha_in),
      .req_dir_x      (req_dir_x),
      .req_dir_y      (req_dir_y),
      .req_dir_z      (req_dir_z),
      .edge_use       (edge_use),
      .q_full         (q_full),
      .q_push         (f_push),
      .q_item         (f_item),
      .q_num_u        (f_num_u),
      .q_num_v        (f_num_v),
      .q_den          (f_den)
   );

   cms_fifo #(.WIDTH(QD), .DEPTH(Q_DEPTH)) u_mid_q (
      .clock (clock),
      .reset (reset),
      .push  (f_push),
      .pop   (q_pop),
      .wdata ({f_item, f_num_u, f_num_v, f_den}),
      .rdata (q_rdata),
      .full  (q_full),
      .empty (q_empty)
   );

   assign {b_item, b_num_u, b_num_v, b_den} = q_rdata;

   cms_back #(
      .MAX_FACE_EDGE    (MAX_FACE_EDGE),
      .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .edge_use (edge_use),
      .q_empty  (q_empty),
      .q_pop    (q_pop),
      .q_item   (b_item),
      .q_num_u  (b_num_u),
      .q_num_v  (b_num_v),
      .q_den    (b_den),
      .out_full (out_full),
      .out_push (out_push),
      .out_data (out_data)
   );

   cms_fifo #(.WIDTH(OD), .DEPTH(OUT_DEPTH)) u_rsp_q (
      .clock (clock),
      .reset (reset),
      .push  (out_push),
      .pop   (pop),
      .wdata (out_data),
      .rdata (rsp_rdata),
      .full  (out_full),
      .empty (empty)
   );

   assign rsp_data           = rsp_rdata;
   assign rsp_red_out        = rsp_data.red;
   assign rsp_green_out      = rsp_data.green;
   assign rsp_blue_out       = rsp_data.blue;
   assign rsp_alpha_out      = rsp_data.alpha;
   assign rsp_hit_face       = rsp_data.face;
   assign rsp_zero_direction = rsp_data.zero;

endmodule

`default_nettype wire
